// File: sv/csc_pkg.sv
// Shared types and constants for the CORDIC sine/cosine pipeline.
// No dependencies; compiled first.
package csc_pkg;

   localparam int unsigned CSC_STAGES     = 32;
   localparam int unsigned CSC_IDX_WIDTH  = $clog2(CSC_STAGES);
   localparam int unsigned CSC_CNT_WIDTH  = 6;
   localparam int unsigned CSC_DATA_WIDTH = 32;

   localparam logic [CSC_CNT_WIDTH-1:0]  CSC_CNT_RESET = 6'd32;
   localparam logic [CSC_CNT_WIDTH-1:0]  CSC_CNT_MAX   = 6'd32;
   localparam logic [CSC_DATA_WIDTH-1:0] CSC_GAIN_INIT = 32'h26DD3B6A;

   typedef logic [CSC_DATA_WIDTH-1:0] word_type;
   typedef logic [CSC_IDX_WIDTH-1:0]  index_type;
   typedef logic [CSC_CNT_WIDTH-1:0]  count_type;

   // Rotation vector carried down the pipe
   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
   } vec_type;

   function automatic word_type atan_entry(input index_type k);
      word_type r;
      case (k)
         5'd0:    r = 32'h3243F6A8;
         5'd1:    r = 32'h1DAC6705;
         5'd2:    r = 32'h0FADBAFC;
         5'd3:    r = 32'h07F56EA6;
         5'd4:    r = 32'h03FEAB76;
         5'd5:    r = 32'h01FFD55B;
         5'd6:    r = 32'h00FFFAAA;
         5'd7:    r = 32'h007FFF55;
         5'd8:    r = 32'h003FFFEA;
         5'd9:    r = 32'h001FFFFD;
         5'd10:   r = 32'h000FFFFF;
         5'd11:   r = 32'h0007FFFF;
         5'd12:   r = 32'h0003FFFF;
         5'd13:   r = 32'h0001FFFF;
         5'd14:   r = 32'h0000FFFF;
         5'd15:   r = 32'h00007FFF;
         5'd16:   r = 32'h00003FFF;
         5'd17:   r = 32'h00001FFF;
         5'd18:   r = 32'h00000FFF;
         5'd19:   r = 32'h000007FF;
         5'd20:   r = 32'h000003FF;
         5'd21:   r = 32'h000001FF;
         5'd22:   r = 32'h000000FF;
         5'd23:   r = 32'h0000007F;
         5'd24:   r = 32'h0000003F;
         5'd25:   r = 32'h0000001F;
         5'd26:   r = 32'h0000000F;
         5'd27:   r = 32'h00000008;
         5'd28:   r = 32'h00000004;
         5'd29:   r = 32'h00000002;
         5'd30:   r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

// File: sv/csc_req_if.sv
// Request channel: one angle per beat, valid/ready handshake.
// Depends on csc_pkg.
interface csc_req_if;
   import csc_pkg::*;
   logic     valid;
   logic     ready;
   word_type angle;

   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

// File: sv/csc_rsp_if.sv
// Response channel: sine and cosine per beat, valid/ready handshake.
// Depends on csc_pkg.
interface csc_rsp_if;
   import csc_pkg::*;
   logic     valid;
   logic     ready;
   word_type sine;
   word_type cosine;

   modport source (output valid, output sine, output cosine, input ready);
   modport sink   (input valid, input sine, input cosine, output ready);
endinterface

// File: sv/cordic_sine_cosine.sv
// CORDIC sine/cosine: 32 pipelined micro-rotation stages, one per table entry.
// Each stage registers its beat; one angle per cycle unless rsp stalls.
// Each stage holds a beat until its successor frees, so a stalled response
// backs up stage by stage while upstream bubbles still fill.
// Reset (synchronous) empties the pipe and sets the iteration count to 32.
module cordic_sine_cosine (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  csc_pkg::count_type csr_write_data,
   csc_req_if.sink         req,
   csc_rsp_if.source       rsp
);
   import csc_pkg::*;

   count_type iter_count_ff;
   count_type iter_clamped;

   logic    valid_w [CSC_STAGES+1];
   logic    ready_w [CSC_STAGES+1];
   vec_type vec_w   [CSC_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_count_ff <= CSC_CNT_RESET;
      end else if (csr_write_enable) begin
         iter_count_ff <= csr_write_data;
      end
   end

   assign iter_clamped = (iter_count_ff > CSC_CNT_MAX) ? CSC_CNT_MAX : iter_count_ff;

   assign valid_w[0] = req.valid;
   assign req.ready  = ready_w[0];
   assign vec_w[0]   = '{x: CSC_GAIN_INIT, y: '0, z: req.angle};

   for (genvar k = 0; k < CSC_STAGES; k++) begin : g_stage
      csc_stage u_stage (
         .clock       (clock),
         .reset       (reset),
         .stage_index (index_type'(k)),
         .active      (count_type'(k) < iter_clamped),
         .in_valid    (valid_w[k]),
         .in_ready    (ready_w[k]),
         .in_vec      (vec_w[k]),
         .out_valid   (valid_w[k+1]),
         .out_ready   (ready_w[k+1]),
         .out_vec     (vec_w[k+1])
      );
   end

   assign rsp.valid           = valid_w[CSC_STAGES];
   assign ready_w[CSC_STAGES] = rsp.ready;
   assign rsp.sine            = vec_w[CSC_STAGES].y;
   assign rsp.cosine          = vec_w[CSC_STAGES].x;

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> iter_count_ff == $past(csr_write_data))
      else $error("iteration count register did not take the written value");

   a_entry: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> valid_w[1])
      else $error("accepted beat did not reach the first stage");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid && !valid_w[1])
      else $error("pipeline not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_w[1] && !ready_w[1]) |=> valid_w[1] && $stable(vec_w[1]))
      else $error("stalled first stage lost or changed its beat");

endmodule

// File: sv/csc_stage.sv
// One CORDIC micro-rotation with its own valid bit and stall logic.
// Depends on csc_pkg; the index input is tied to a constant per instance.
module csc_stage (
   input  logic              clock,
   input  logic              reset,
   input  csc_pkg::index_type stage_index,
   input  logic              active,
   input  logic              in_valid,
   output logic              in_ready,
   input  csc_pkg::vec_type  in_vec,
   output logic              out_valid,
   input  logic              out_ready,
   output csc_pkg::vec_type  out_vec
);
   import csc_pkg::*;

   logic     valid_ff;
   vec_type  vec_ff;
   vec_type  vec_in;
   word_type x_sh;
   word_type y_sh;
   word_type atan;
   logic     neg;

   // stage can take a beat if empty or its content moves on this cycle
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

   always_comb begin
      neg  = in_vec.z[CSC_DATA_WIDTH-1];
      x_sh = word_type'($signed(in_vec.x) >>> stage_index);
      y_sh = word_type'($signed(in_vec.y) >>> stage_index);
      atan = atan_entry(stage_index);
      vec_in = in_vec;
      if (active) begin
         if (neg) begin
            vec_in.x = in_vec.x + y_sh;
            vec_in.y = in_vec.y - x_sh;
            vec_in.z = in_vec.z + atan;
         end else begin
            vec_in.x = in_vec.x - y_sh;
            vec_in.y = in_vec.y + x_sh;
            vec_in.z = in_vec.z - atan;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

endmodule

// File: sim/csc_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the CORDIC sine/cosine unit: watches both channels and the csr port,
// predicts sine/cosine per accepted angle and compares in order.
// Depends on csc_pkg, csc_req_if and csc_rsp_if.
module csc_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  csc_pkg::count_type csr_write_data,
   csc_req_if                 req,
   csc_rsp_if                 rsp,
   output int unsigned        fail_count,
   output int unsigned        pending
);
   import csc_pkg::*;

   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      word_type angle;
      word_type sine;
      word_type cosine;
   } trig_pair_type;

   word_type      arctan_lut [32];
   trig_pair_type expected_q [$];
   count_type     iter_count = CSC_CNT_RESET;
   int unsigned   errors = 0;

   initial begin
      arctan_lut = '{
         32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
         32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
         32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
         32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
         32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
         32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
         32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
         32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
      };
   end

   // Rotation-mode micro-rotations; everything wraps at 32 bits
   function automatic trig_pair_type cordic_rotate(input word_type angle,
                                                   input count_type count);
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      int unsigned        n;
      trig_pair_type      r;
      n = (count > CSC_CNT_MAX) ? CSC_CNT_MAX : count;
      x = CSC_GAIN_INIT;
      y = '0;
      z = angle;
      for (int k = 0; k < n; k++) begin
         if (z[31]) begin
            nx = x + (y >>> k);
            ny = y - (x >>> k);
            z  = z + arctan_lut[k];
         end else begin
            nx = x - (y >>> k);
            ny = y + (x >>> k);
            z  = z - arctan_lut[k];
         end
         x = nx;
         y = ny;
      end
      r.angle  = angle;
      r.sine   = y;
      r.cosine = x;
      return r;
   endfunction

   always @(posedge clock) begin : track
      trig_pair_type want;
      if (reset) begin
         expected_q.delete();
         iter_count = CSC_CNT_RESET;
      end else begin
         if (csr_write_enable) begin
            iter_count = csr_write_data;
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result beat: sine %h cosine %h",
                           $realtime, rsp.sine, rsp.cosine);
               end
            end else begin
               want = expected_q.pop_front();
               if (rsp.sine !== want.sine || rsp.cosine !== want.cosine) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display("%0t: angle %h: sine/cosine expected %h/%h, got %h/%h",
                              $realtime, want.angle, want.sine, want.cosine,
                              rsp.sine, rsp.cosine);
                  end
               end
            end
         end
         if (req.valid && req.ready) begin
            expected_q.push_back(cordic_rotate(req.angle, iter_count));
         end
      end
      fail_count <= errors;
      pending    <= expected_q.size();
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the cordic_sine_cosine regression: clock, reset, stimulus and verdict.
// Depends on csc_pkg, the channel interfaces, cordic_sine_cosine and csc_checker.
module tb_top;
   import csc_pkg::*;

   localparam int unsigned ITEMS_PER_PHASE = 217;
   localparam int unsigned WATCHDOG_LIMIT  = 2000;
   localparam int unsigned TAIL_CYCLES     = 40;
   localparam word_type    ANGLE_LIMIT     = 32'd1686629713;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   count_type   csr_write_data;
   int unsigned fail_count;
   int unsigned pending;
   int unsigned idle_cycles = 0;
   int unsigned burst_left = 0;

   csc_req_if req_ch ();
   csc_rsp_if rsp_ch ();

   cordic_sine_cosine dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch)
   );

   csc_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Nothing accepted on either channel for too long: give up
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("cordic_sine_cosine regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: ready follows an 8-slot mask, reloaded every run; some runs stall outright
   initial begin : rsp_stall
      logic [7:0]  mask;
      int unsigned run_left;
      int unsigned slot;
      rsp_ch.ready <= 1'b0;
      mask     = 8'hFF;
      run_left = 0;
      slot     = 0;
      forever begin
         @(posedge clock);
         if (run_left == 0) begin
            run_left = $urandom_range(8, 80);
            case ($urandom_range(0, 5))
               0, 1: mask = 8'hFF;
               2, 3: mask = 8'($urandom_range(1, 255));
               4: mask = 8'h01 << $urandom_range(0, 7);
               default: begin
                  mask     = 8'h00;
                  run_left = $urandom_range(8, 40);
               end
            endcase
         end
         rsp_ch.ready <= mask[slot];
         slot = (slot + 1) % 8;
         run_left--;
      end
   end

   function automatic word_type random_angle();
      word_type a;
      case ($urandom_range(0, 9))
         0: a = $urandom();                              // anything, out of range too
         1: a = $urandom_range(0, 1023) - 32'd512;      // near zero
         2: a = $urandom_range(0, 1) ? ANGLE_LIMIT - $urandom_range(0, 255)
                                     : -ANGLE_LIMIT + $urandom_range(0, 255);
         default: a = $urandom_range(0, 32'd3373259426) - ANGLE_LIMIT;
      endcase
      return a;
   endfunction

   task automatic send_angle(input word_type a);
      req_ch.valid <= 1'b1;
      req_ch.angle <= a;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Bursts of random length, random gaps; a gap of zero keeps valid high
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left != 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 47);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         req_ch.angle <= $urandom();
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_pipe();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_iter_count(input count_type v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      word_type  corner_angles [14];
      count_type iter_settings [8];
      corner_angles = '{
         32'h00000000, 32'h00000001, 32'hFFFFFFFF, 32'h6487ED51,
         32'h9B7812AF, 32'h3243F6A8, 32'hCDBC0958, 32'h40000000,
         32'hC0000000, 32'h80000000, 32'h7FFFFFFF, 32'h00000008,
         32'h55555555, 32'hAAAAAAAA
      };
      // zero and 63 are the extremes; 33 and 63 exercise the clamp
      iter_settings = '{6'd0, 6'd1, 6'd63, 6'd33, 6'd31, 6'd16, 6'd0, 6'd32};
      iter_settings[6] = $urandom_range(0, 63);

      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= CSC_CNT_RESET;
      req_ch.valid     <= 1'b0;
      req_ch.angle     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset count first, corners back to back
      foreach (corner_angles[i]) begin
         send_angle(corner_angles[i]);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
         send_angle(random_angle());
         pace_sender();
      end

      foreach (iter_settings[p]) begin
         drain_pipe();
         write_iter_count(iter_settings[p]);
         send_angle(corner_angles[$urandom_range(0, 13)]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_angle(random_angle());
            if ($urandom_range(0, 199) == 0) begin
               drain_pipe();
            end else begin
               pace_sender();
            end
         end
      end

      drain_pipe();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("cordic_sine_cosine regression: pass");
      end else begin
         $display("cordic_sine_cosine regression: fail");
      end
      $finish;
   end

endmodule

// File: cordic_sine_cosine.f
sv/csc_pkg.sv
sv/csc_req_if.sv
sv/csc_rsp_if.sv
sv/csc_stage.sv
sv/cordic_sine_cosine.sv
sim/csc_checker.sv
sim/tb_top.sv
